/* sv/polygon_convexity_winding_macros.svh */
// Assertion helpers for the polygon convexity and winding block.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef POLYGON_CONVEXITY_WINDING_MACROS_SVH
`define POLYGON_CONVEXITY_WINDING_MACROS_SVH

// Same-cycle implication.
`define PCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pcw_pkg.sv */
`timescale 1ns / 1ps

package pcw_pkg;

    // Orientation of one vertex triple, two's complement.
    typedef logic signed [1:0] turn_t;

    localparam turn_t TURN_NONE = 2'sb00;
    localparam turn_t TURN_POS  = 2'sb01;
    localparam turn_t TURN_NEG  = 2'sb11;

    // Result tdata: is_convex, winding, enough_vertices, zero fill.
    localparam int OUT_W = 8;

    // Control that travels with one vertex into the accumulator.
    typedef struct packed {
        logic valid;    // vertex retires this cycle
        logic last;     // final vertex of the polygon
        logic main_en;  // consecutive triple is defined
        logic wrap_en;  // the two wrap-around triples apply
    } acc_step_t;

endpackage

/* sv/pcw_orient.sv */
`timescale 1ns / 1ps

module pcw_orient #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic [COORD_BITS-1:0] ax,
    input  logic [COORD_BITS-1:0] ay,
    input  logic [COORD_BITS-1:0] bx,
    input  logic [COORD_BITS-1:0] by,
    input  logic [COORD_BITS-1:0] cx,
    input  logic [COORD_BITS-1:0] cy,
    output pcw_pkg::turn_t        turn
);
    import pcw_pkg::*;

    localparam int DW = COORD_BITS + 1;      // signed difference
    localparam int PW = 2 * DW;              // signed product
    localparam int QW = 2 * COORD_BITS;      // magnitude of one square
    localparam int SW = 2 * COORD_BITS + 1;  // squared distance

    logic signed [DW-1:0] dx1, dy1, dx2, dy2;
    logic signed [PW-1:0] p_next, q_next;
    logic signed [PW-1:0] sqx1, sqy1, sqx2, sqy2;
    logic        [SW-1:0] s1_next, s2_next;
    logic                 opp_next;

    logic signed [PW-1:0] p_reg, q_reg;
    logic        [SW-1:0] s1_reg, s2_reg;
    logic                 opp_reg;

    assign dx1 = $signed({1'b0, bx}) - $signed({1'b0, ax});
    assign dy1 = $signed({1'b0, by}) - $signed({1'b0, ay});
    assign dx2 = $signed({1'b0, cx}) - $signed({1'b0, ax});
    assign dy2 = $signed({1'b0, cy}) - $signed({1'b0, ay});

    assign p_next = PW'(dx1) * PW'(dy2);
    assign q_next = PW'(dy1) * PW'(dx2);
    assign sqx1   = PW'(dx1) * PW'(dx1);
    assign sqy1   = PW'(dy1) * PW'(dy1);
    assign sqx2   = PW'(dx2) * PW'(dx2);
    assign sqy2   = PW'(dy2) * PW'(dy2);

    assign s1_next = {1'b0, sqx1[QW-1:0]} + {1'b0, sqy1[QW-1:0]};
    assign s2_next = {1'b0, sqx2[QW-1:0]} + {1'b0, sqy2[QW-1:0]};

    // Collinear points on opposite sides of a along either axis.
    assign opp_next =
        (dx1[DW-1] && !dx2[DW-1] && (dx2 != '0)) ||
        (dx2[DW-1] && !dx1[DW-1] && (dx1 != '0)) ||
        (dy1[DW-1] && !dy2[DW-1] && (dy2 != '0)) ||
        (dy2[DW-1] && !dy1[DW-1] && (dy1 != '0));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_reg   <= p_next;
            q_reg   <= q_next;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            opp_reg <= opp_next;
        end
    end

    always_comb
    begin
        priority if (p_reg > q_reg)
            turn = TURN_POS;
        else if (p_reg < q_reg)
            turn = TURN_NEG;
        else if (opp_reg)
            turn = TURN_NEG;
        else if (s1_reg < s2_reg)
            turn = TURN_POS;
        else
            turn = TURN_NONE;
    end

endmodule

/* sv/pcw_turn_acc.sv */
`timescale 1ns / 1ps

module pcw_turn_acc #(
    parameter int SUM_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pcw_pkg::acc_step_t step,
    input  pcw_pkg::turn_t     turn_main,
    input  pcw_pkg::turn_t     turn_wrap_a,
    input  pcw_pkg::turn_t     turn_wrap_b,
    output logic               is_convex,
    output pcw_pkg::turn_t     winding,
    output logic               enough_vertices
);
    import pcw_pkg::*;

    turn_t                      ref_reg, ref_next;
    logic                       mm_reg, mm_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    turn_t                      turns_g [3];

    // Add one turn and clamp to the signed SUM_BITS range.
    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0] s,
        input turn_t                      t
    );
        logic signed [SUM_BITS:0] ext;
        ext = {s[SUM_BITS-1], s} + (SUM_BITS + 1)'(t);
        if (ext[SUM_BITS] != ext[SUM_BITS-1])
            sat_add = ext[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                    : {1'b0, {(SUM_BITS-1){1'b1}}};
        else
            sat_add = ext[SUM_BITS-1:0];
    endfunction

    always_comb
    begin
        turns_g[0] = step.main_en ? turn_main   : TURN_NONE;
        turns_g[1] = step.wrap_en ? turn_wrap_a : TURN_NONE;
        turns_g[2] = step.wrap_en ? turn_wrap_b : TURN_NONE;

        ref_next = ref_reg;
        mm_next  = mm_reg;
        sum_next = sum_reg;
        // Turns are taken in order: main triple, then the two wrap triples.
        for (int k = 0; k < 3; k++)
        begin
            if (turns_g[k] != TURN_NONE)
            begin
                if (ref_next != TURN_NONE && ref_next != turns_g[k])
                    mm_next = 1'b1;
                if (ref_next == TURN_NONE)
                    ref_next = turns_g[k];
            end
            sum_next = sat_add(sum_next, turns_g[k]);
        end

        enough_vertices = step.wrap_en;
        is_convex       = step.wrap_en & ~mm_next;
        priority if (!step.wrap_en)
            winding = TURN_NONE;
        else if (sum_next > 0)
            winding = TURN_POS;
        else if (sum_next < 0)
            winding = TURN_NEG;
        else
            winding = TURN_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= TURN_NONE;
            mm_reg  <= 1'b0;
            sum_reg <= '0;
        end
        else if (step.valid)
        begin
            if (step.last)
            begin
                ref_reg <= TURN_NONE;
                mm_reg  <= 1'b0;
                sum_reg <= '0;
            end
            else
            begin
                ref_reg <= ref_next;
                mm_reg  <= mm_next;
                sum_reg <= sum_next;
            end
        end
    end

endmodule

/* sv/polygon_convexity_winding.sv */
`timescale 1ns / 1ps
// A final vertex goes through stage 1 and then the result register.
// Throughput: one vertex per cycle; the block stalls only when a finished
// result is held in the output register and another final vertex waits.
// Reset (rst_n low, asynchronous): clears the vertex history, the vertex count,
// the orientation accumulator and all valid flags; no result is pending.
module polygon_convexity_winding #(
    parameter int COORD_BITS = 16,
    parameter int SUM_BITS   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: vertex_x, vertex_y, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tlast: is_last
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata: is_convex, winding[1:0], enough_vertices, zero fill
    output logic [pcw_pkg::OUT_W-1:0]  m_axis_tdata
);
    import pcw_pkg::*;

    `include "polygon_convexity_winding_macros.svh"

    localparam int CB = COORD_BITS;

    // ------------------------------------------------------------------
    // Input side: vertex history. seen_cnt_reg counts vertices before the
    // current one and saturates at three.
    // ------------------------------------------------------------------
    logic [CB-1:0] cur_x, cur_y;
    logic [CB-1:0] second_x_reg, second_y_reg, third_x_reg, third_y_reg;
    logic [CB-1:0] older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic [CB-1:0] third_x, third_y;
    logic [1:0]    seen_cnt_reg;
    logic          s_accept;

    // Stage 1: products registered inside the orientation units.
    logic          s1_vld_reg, s1_last_reg, s1_main_reg, s1_wrap_reg;
    logic          s1_retire;

    // Result register.
    logic          out_vld_reg, out_convex_reg, out_enough_reg;
    turn_t         out_wind_reg;
    logic          out_en;

    turn_t         turn_main, turn_wrap_a, turn_wrap_b;
    acc_step_t     step;
    logic          res_convex, res_enough;
    turn_t         res_wind;

    assign cur_x = s_axis_tdata[CB-1:0];
    assign cur_y = s_axis_tdata[2*CB-1:CB];

    // With exactly three vertices the third is the one arriving now.
    assign third_x = (seen_cnt_reg == 2'd2) ? cur_x : third_x_reg;
    assign third_y = (seen_cnt_reg == 2'd2) ? cur_y : third_y_reg;

    // A non-final vertex in stage 1 retires freely; a final one needs the
    // result register to be free or draining.
    assign out_en        = !out_vld_reg || m_axis_tready;
    assign s1_retire     = !s1_last_reg || out_en;
    assign s_axis_tready = !s1_vld_reg || s1_retire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_x_reg <= '0;
            second_y_reg <= '0;
            third_x_reg  <= '0;
            third_y_reg  <= '0;
            older_x_reg  <= '0;
            older_y_reg  <= '0;
            newer_x_reg  <= '0;
            newer_y_reg  <= '0;
            seen_cnt_reg <= '0;
        end
        else if (s_accept)
        begin
            if (s_axis_tlast)
            begin
                // Polygon closed: start over for the next one.
                second_x_reg <= '0;
                second_y_reg <= '0;
                third_x_reg  <= '0;
                third_y_reg  <= '0;
                older_x_reg  <= '0;
                older_y_reg  <= '0;
                newer_x_reg  <= '0;
                newer_y_reg  <= '0;
                seen_cnt_reg <= '0;
            end
            else
            begin
                if (seen_cnt_reg == 2'd1)
                begin
                    second_x_reg <= cur_x;
                    second_y_reg <= cur_y;
                end
                if (seen_cnt_reg == 2'd2)
                begin
                    third_x_reg <= cur_x;
                    third_y_reg <= cur_y;
                end
                older_x_reg <= newer_x_reg;
                older_y_reg <= newer_y_reg;
                newer_x_reg <= cur_x;
                newer_y_reg <= cur_y;
                if (seen_cnt_reg != 2'd3)
                    seen_cnt_reg <= seen_cnt_reg + 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 control. The three orientation units load on the same edge.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s1_main_reg <= 1'b0;
            s1_wrap_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_vld_reg  <= 1'b1;
            s1_last_reg <= s_axis_tlast;
            s1_main_reg <= seen_cnt_reg[1];
            s1_wrap_reg <= s_axis_tlast && seen_cnt_reg[1];
        end
        else if (s1_retire)
        begin
            s1_vld_reg <= 1'b0;
        end
    end

    // Consecutive triple (older, newer, current).
    pcw_orient #(.COORD_BITS(COORD_BITS)) u_orient_main (
        .clk  (clk),
        .load (s_accept),
        .ax   (older_x_reg),
        .ay   (older_y_reg),
        .bx   (newer_x_reg),
        .by   (newer_y_reg),
        .cx   (cur_x),
        .cy   (cur_y),
        .turn (turn_main)
    );

    // First wrap triple (newer, current, second).
    pcw_orient #(.COORD_BITS(COORD_BITS)) u_orient_wrap_a (
        .clk  (clk),
        .load (s_accept),
        .ax   (newer_x_reg),
        .ay   (newer_y_reg),
        .bx   (cur_x),
        .by   (cur_y),
        .cx   (second_x_reg),
        .cy   (second_y_reg),
        .turn (turn_wrap_a)
    );

    // Second wrap triple (current, second, third).
    pcw_orient #(.COORD_BITS(COORD_BITS)) u_orient_wrap_b (
        .clk  (clk),
        .load (s_accept),
        .ax   (cur_x),
        .ay   (cur_y),
        .bx   (second_x_reg),
        .by   (second_y_reg),
        .cx   (third_x),
        .cy   (third_y),
        .turn (turn_wrap_b)
    );

    // ------------------------------------------------------------------
    // Stage 2: orientation accumulator and result register.
    // ------------------------------------------------------------------
    assign step.valid   = s1_vld_reg && s1_retire;
    assign step.last    = s1_last_reg;
    assign step.main_en = s1_main_reg;
    assign step.wrap_en = s1_wrap_reg;

    pcw_turn_acc #(.SUM_BITS(SUM_BITS)) u_turn_acc (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .turn_main       (turn_main),
        .turn_wrap_a     (turn_wrap_a),
        .turn_wrap_b     (turn_wrap_b),
        .is_convex       (res_convex),
        .winding         (res_wind),
        .enough_vertices (res_enough)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step.valid && step.last)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid && step.last)
        begin
            out_convex_reg <= res_convex;
            out_wind_reg   <= res_wind;
            out_enough_reg <= res_enough;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_W-4){1'b0}}, out_enough_reg, out_wind_reg, out_convex_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PCW_ASSERT_NOW(a_convex_needs_enough,
        m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[3],
        "convex result without three vertices")
    `PCW_ASSERT_NOW(a_short_winding_zero,
        m_axis_tvalid && !m_axis_tdata[3], m_axis_tdata[2:1] == 2'b00,
        "nonzero winding on a short polygon")
    `PCW_ASSERT_NEXT(a_count_clears,
        s_accept && s_axis_tlast, seen_cnt_reg == 2'd0,
        "vertex count not cleared after final vertex")
    `PCW_ASSERT_NOW(a_stall_cause,
        !s_axis_tready, s1_vld_reg && s1_last_reg && out_vld_reg,
        "input stalled without a blocked final vertex")

endmodule
